// File: rtl/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key-value cache checker.
// No dependencies; each macro expects clk in the enclosing scope, and all but LKVC_ASSERT_RST also rst_n.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define LKVC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by the controller, the datapath and the top level; no dependencies.
package lkvc_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/lru_key_value_cache.sv
// LRU key-value cache top level: stream ports, controller and datapath.
// A get result passes LOOK, APPLY and EMIT into the output register; it waits in EMIT on a stall.
// One item at a time: a new item is taken only in IDLE, after LOOK, APPLY and (for a get) EMIT.
// Reset (rst_n, synchronous, active low) clears valid marks, ranks, occupancy and state,
// and sets capacity to 16. No clearing pass; an item may be taken in the cycle after reset.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data,   // capacity_in_use
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // key [31:0], value [63:32]
  input  logic [0:0]                  in_tuser,   // mode [0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // read_value [31:0]
  output logic [0:0]                  out_tuser   // found [0]
);

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  assign cfg_ready = rst_n;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_mode   (in_tuser[0]),
    .in_key    (in_tdata[31:0]),
    .in_value  (in_tdata[63:32]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (out_tuser[0]),
    .out_data  (out_tdata)
  );

endmodule

// File: rtl/lkvc_ctrl.sv
// Controller state machine for the LRU key-value cache.
// Depends on lkvc_pkg; drives lkvc_dp through cmd_t and reads sts_t.
module lkvc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  lkvc_pkg::sts_t  sts,
  output lkvc_pkg::cmd_t  cmd
);

  lkvc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        in_tready   = rst_n;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = lkvc_pkg::ST_LOOK;
        end
      end
      lkvc_pkg::ST_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = lkvc_pkg::ST_APPLY;
      end
      lkvc_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = sts.is_get ? lkvc_pkg::ST_EMIT : lkvc_pkg::ST_IDLE;
      end
      lkvc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lkvc_dp.sv
// Datapath for the LRU key-value cache: key lanes, ranks, value memory, output register.
// Depends on lkvc_pkg; sequenced by lkvc_ctrl through cmd_t.
module lkvc_dp #(
  parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkvc_pkg::cmd_t              cmd,
  output lkvc_pkg::sts_t              sts,
  input  logic                        cfg_valid,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data,
  input  logic                        in_mode,
  input  logic [lkvc_pkg::KEY_W-1:0]  in_key,
  input  logic [lkvc_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [lkvc_pkg::VAL_W-1:0]  out_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  logic                       mode_r;
  logic [lkvc_pkg::KEY_W-1:0] key_r;
  logic [lkvc_pkg::VAL_W-1:0] val_r;

  logic [ENTRIES-1:0]         valid_r;
  logic [lkvc_pkg::KEY_W-1:0] key_mem_r [ENTRIES];
  logic [IW-1:0]              rank_r    [ENTRIES];
  logic [CW-1:0]              occ_r;
  logic [lkvc_pkg::VAL_W-1:0] vmem      [ENTRIES];

  logic          hit_r, act_r, ins_r;
  logic [IW-1:0] tgt_r;
  logic [CW-1:0] thr_r;
  logic [lkvc_pkg::VAL_W-1:0] rdata_r;

  logic                       out_valid_r, out_found_r;
  logic [lkvc_pkg::VAL_W-1:0] out_data_r;

  logic          hit_c, vic_c, free_c, evict_c;
  logic [IW-1:0] hit_idx_c, vic_idx_c, free_idx_c;
  logic [CW-1:0] hit_rank_c;
  logic [EW-1:0] cap_eff_c, occ_ext_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_value;
    end
  end

  always_comb begin
    cap_eff_c = EW'(cap_r);
    if (cap_eff_c == '0) begin
      cap_eff_c = EW'(1);
    end else if (cap_eff_c > EW'(ENTRIES)) begin
      cap_eff_c = EW'(ENTRIES);
    end
    occ_ext_c = EW'(occ_r);
  end

  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    hit_rank_c = '0;
    vic_c      = 1'b0;
    vic_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_mem_r[i] == key_r) begin
        hit_c      = 1'b1;
        hit_idx_c  = IW'(i);
        hit_rank_c = CW'(rank_r[i]);
      end
      if (valid_r[i] && CW'(rank_r[i]) == occ_r - CW'(1)) begin
        vic_c     = 1'b1;
        vic_idx_c = IW'(i);
      end
      if (!valid_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
    evict_c = (occ_ext_c >= cap_eff_c) && (occ_r != '0) && vic_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r <= hit_c;
      if (hit_c) begin
        tgt_r <= hit_idx_c;
        thr_r <= hit_rank_c;
        ins_r <= 1'b0;
        act_r <= 1'b1;
      end else if (evict_c) begin
        tgt_r <= vic_idx_c;
        thr_r <= occ_r - CW'(1);
        ins_r <= 1'b0;
        act_r <= (mode_r == lkvc_pkg::MODE_SET);
      end else begin
        tgt_r <= free_idx_c;
        thr_r <= occ_r;
        ins_r <= (mode_r == lkvc_pkg::MODE_SET) && free_c;
        act_r <= (mode_r == lkvc_pkg::MODE_SET) && free_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.apply && act_r) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_r == IW'(i)) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && CW'(rank_r[i]) < thr_r) begin
          rank_r[i] <= rank_r[i] + IW'(1);
        end
      end
      if (ins_r) begin
        valid_r[tgt_r] <= 1'b1;
        occ_r          <= occ_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && act_r && mode_r == lkvc_pkg::MODE_SET) begin
      key_mem_r[tgt_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && act_r && mode_r == lkvc_pkg::MODE_SET) begin
      vmem[tgt_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && mode_r == lkvc_pkg::MODE_GET) begin
      rdata_r <= vmem[tgt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r <= hit_r;
      out_data_r  <= hit_r ? rdata_r : '1;
    end
  end

  assign sts.is_get   = (mode_r == lkvc_pkg::MODE_GET);
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_data     = out_data_r;

endmodule

// File: rtl/lkvc_chk.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lru_key_value_cache_defines.svh for the assertion macros.
`include "lru_key_value_cache_defines.svh"

module lkvc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  `LKVC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `LKVC_ASSERT_NOW(a_miss_value, out_tvalid && !out_tuser[0], out_tdata == 32'hFFFF_FFFF, "miss value not all ones")
  `LKVC_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second item taken during lookup")
  `LKVC_ASSERT_RST(a_reset_quiet, !rst_n, !out_tvalid, "result shown after reset")

endmodule

bind lru_key_value_cache lkvc_chk u_chk (.*);
